// ===== hdl/first_fit_segment_allocator_assert.svh =====
// assertion macros shared by the allocator checker
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define FFSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ffsa_pkg.sv =====
package ffsa_pkg;

  // request operation codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_PLACE = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // register indexes
  localparam logic CFG_POOL_BASE   = 1'b0;
  localparam logic CFG_POOL_LENGTH = 1'b1;

  localparam logic [31:0] POOL_RST = 32'h0010_0000;

  // one table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        used;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PLAN,
    S_BUILD,
    S_SHIFT,
    S_PIECE,
    S_MERGE,
    S_FLUSH,
    S_DONE
  } state_e;

endpackage

// ===== hdl/ffsa_seg_ram.sv =====
module ffsa_seg_ram #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  ffsa_pkg::seg_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output ffsa_pkg::seg_t rdata_o
);
  import ffsa_pkg::*;

  seg_t mem_q [DEPTH];
  seg_t rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/first_fit_segment_allocator.sv =====
// a request is served by a scan pass and a merge pass over the table, plus an entry shift
// on a split; a free needs no shift
// one request at a time; the next can be taken while the result is offered
// reset or a register write rebuilds the table with one free segment;
// that entry is written before the first request is taken
module first_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] req_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] grant_address_o,
  output logic [31:0] free_bytes_o
);
  import ffsa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  state_e state_q, state_d;
  logic init_q, init_d;
  logic [31:0] base_q, base_d, plen_q, plen_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0] func_q, func_d;
  logic [31:0] size_q, size_d, addr_q, addr_d;
  logic [CW-1:0] rp_q, rp_d, ri_q, ri_d;
  logic rv_q, rv_d;
  logic hit_q, hit_d, ex_q, ex_d, found_q, found_d;
  logic [CW-1:0] hidx_q, hidx_d, eidx_q, eidx_d, sidx_q, sidx_d;
  seg_t hseg_q, hseg_d, eseg_q, eseg_d, sseg_q, sseg_d;
  logic [31:0] diff_q, diff_d;
  seg_t pc0_q, pc0_d, pc1_q, pc1_d, pc2_q, pc2_d;
  logic [1:0] npc_q, npc_d, pk_q, pk_d;
  logic [1:0] st_q, st_d;
  logic [31:0] grant_q, grant_d;
  logic merge_q, merge_d;
  logic [CW-1:0] w_q, w_d;
  seg_t pend_q, pend_d;
  logic pv_q, pv_d;
  logic [31:0] sum_q, sum_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [31:0] gout_q, gout_d, free_q, free_d;

  logic ram_we;
  logic [CW-1:0] wa_full;
  seg_t ram_wd, ram_rd;

  // segment table
  ffsa_seg_ram #(.DEPTH(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_full[IW-1:0]),
    .wdata_i (ram_wd),
    .raddr_i (rp_q[IW-1:0]),
    .rdata_o (ram_rd)
  );

  // scan compares on the entry just read
  logic [31:0] off_w;
  logic fit_place, stop;
  always_comb begin
    off_w = addr_q - ram_rd.start - HDR;
    fit_place = !ram_rd.used && (off_w <= ram_rd.len)
                && (({1'b0, off_w} + {1'b0, size_q}) <= {1'b0, ram_rd.len});
    stop = (func_q == FUNC_ALLOC) ? ex_q : ((func_q == FUNC_NONE) || hit_q);
  end

  // piece planning for the chosen segment
  logic [31:0] tail, inlen, len0;
  logic split, pre, suf, small_gap, room;
  logic [1:0] need2;
  always_comb begin
    tail  = sseg_q.len - diff_q - size_q;
    split = (diff_q > HDR) && (count_q < MAXC);
    pre   = diff_q != '0;
    suf   = tail > HDR;
    inlen = suf ? size_q : size_q + tail;
    need2 = {1'b0, pre} + {1'b0, suf};
    small_gap = pre && (diff_q < HDR);
    room  = ({1'b0, count_q} + (CW+1)'(need2)) <= {1'b0, MAXC};
    len0  = (plen_q >= HDR) ? plen_q - HDR : '0;
  end

  // saturating accumulators for merge and free bytes
  logic [33:0] mlen;
  logic [32:0] sadd;
  logic [31:0] sum_nx;
  always_comb begin
    mlen = {2'b0, pend_q.len} + {2'b0, HDR} + {2'b0, ram_rd.len};
    sadd = {1'b0, sum_q} + {1'b0, pend_q.len};
    if (pend_q.used) begin
      sum_nx = sum_q;
    end else begin
      sum_nx = sadd[32] ? '1 : sadd[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;   init_d = init_q;   base_d = base_q;   plen_d = plen_q;
    count_d = count_q;   func_d = func_q;   size_d = size_q;   addr_d = addr_q;
    rp_d = rp_q;         ri_d = rp_q;       rv_d = 1'b0;
    hit_d = hit_q;       hidx_d = hidx_q;   hseg_d = hseg_q;
    ex_d = ex_q;         eidx_d = eidx_q;   eseg_d = eseg_q;
    found_d = found_q;   sidx_d = sidx_q;   sseg_d = sseg_q;   diff_d = diff_q;
    pc0_d = pc0_q;       pc1_d = pc1_q;     pc2_d = pc2_q;     npc_d = npc_q;
    pk_d = pk_q;         st_d = st_q;       grant_d = grant_q; merge_d = merge_q;
    w_d = w_q;           pend_d = pend_q;   pv_d = pv_q;       sum_d = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q; gout_d = gout_q;   free_d = free_q;
    ram_we = 1'b0;       wa_full = '0;      ram_wd = pend_q;
    in_ready_o = (state_q == S_IDLE) && !init_q;

    case (state_q)
      S_IDLE: begin
        if (init_q && !cfg_we_i) begin
          ram_we = 1'b1;
          ram_wd = '{start: base_q, len: len0, used: 1'b0};
          init_d = 1'b0;
        end else if (in_valid_i && in_ready_o) begin
          func_d = func_i;
          size_d = req_size_i;
          addr_d = req_address_i;
          hit_d = 1'b0;
          ex_d = 1'b0;
          rp_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stop && rp_q < count_q) begin
          rv_d = 1'b1;
          rp_d = rp_q + 1'b1;
        end
        if (rv_q && !stop) begin
          case (func_q)
            FUNC_ALLOC: begin
              if (!ram_rd.used && ram_rd.len == size_q) begin
                ex_d = 1'b1; eidx_d = ri_q; eseg_d = ram_rd;
              end
              if (!ram_rd.used && ram_rd.len >= size_q && !hit_q) begin
                hit_d = 1'b1; hidx_d = ri_q; hseg_d = ram_rd;
              end
            end
            FUNC_FREE: begin
              if (ram_rd.used && (ram_rd.start + HDR == addr_q) && addr_q != '0) begin
                hit_d = 1'b1; hidx_d = ri_q; hseg_d = ram_rd;
              end
            end
            FUNC_PLACE: begin
              if (fit_place) begin
                hit_d = 1'b1; hidx_d = ri_q; hseg_d = ram_rd;
              end
            end
            default: ;
          endcase
        end
        if (!rv_q && (stop || rp_q >= count_q)) begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        // exact fit wins over first fit
        if (func_q == FUNC_ALLOC && ex_q) begin
          sseg_d = eseg_q; sidx_d = eidx_q;
        end else begin
          sseg_d = hseg_q; sidx_d = hidx_q;
        end
        found_d = hit_q || (func_q == FUNC_ALLOC && ex_q);
        if (func_q == FUNC_ALLOC) begin
          diff_d = ((ex_q) ? eseg_q.len : hseg_q.len) - size_q;
        end else begin
          diff_d = addr_q - hseg_q.start - HDR;
        end
        state_d = S_BUILD;
      end
      S_BUILD: begin
        npc_d = 2'd0; st_d = STAT_NOFIT; grant_d = '0; merge_d = 1'b0;
        case (func_q)
          FUNC_ALLOC: begin
            if (found_q) begin
              pc0_d = '{start: sseg_q.start, len: split ? size_q : sseg_q.len, used: 1'b1};
              pc1_d = '{start: sseg_q.start + HDR + size_q, len: diff_q - HDR, used: 1'b0};
              npc_d = split ? 2'd2 : 2'd1;
              st_d = STAT_OK;
              grant_d = sseg_q.start + HDR;
            end
          end
          FUNC_FREE: begin
            merge_d = 1'b1;
            if (found_q) begin
              pc0_d = '{start: sseg_q.start, len: sseg_q.len, used: 1'b0};
              npc_d = 2'd1;
              st_d = STAT_OK;
            end
          end
          FUNC_PLACE: begin
            if (found_q && !small_gap) begin
              if (!room) begin
                st_d = STAT_FULL;
              end else begin
                st_d = STAT_OK;
                grant_d = addr_q;
                merge_d = 1'b1;
                npc_d = 2'd1 + need2;
                if (pre) begin
                  pc0_d = '{start: sseg_q.start, len: diff_q - HDR, used: 1'b0};
                  pc1_d = '{start: addr_q - HDR, len: inlen, used: 1'b1};
                  pc2_d = '{start: addr_q + size_q, len: tail - HDR, used: 1'b0};
                end else begin
                  pc0_d = '{start: sseg_q.start, len: inlen, used: 1'b1};
                  pc1_d = '{start: addr_q + size_q, len: tail - HDR, used: 1'b0};
                end
              end
            end
          end
          default: ;
        endcase
        state_d = S_PIECE;
        pk_d = '0;
        rp_d = count_q - 1'b1;
        if (npc_d == 2'd0) begin
          rp_d = '0; w_d = '0; pv_d = 1'b0; sum_d = '0;
          state_d = S_MERGE;
        end else if (npc_d > 2'd1 && (count_q - 1'b1) > sidx_q) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // move the entries above the chosen one up, top first
        if (rp_q > sidx_q) begin
          rv_d = 1'b1;
          rp_d = rp_q - 1'b1;
        end
        if (rv_q) begin
          ram_we = 1'b1;
          ram_wd = ram_rd;
          wa_full = ri_q + CW'(npc_q - 2'd1);
        end
        if (!rv_q && rp_q <= sidx_q) begin
          pk_d = '0;
          state_d = S_PIECE;
        end
      end
      S_PIECE: begin
        ram_we = 1'b1;
        wa_full = sidx_q + CW'(pk_q);
        case (pk_q)
          2'd0:    ram_wd = pc0_q;
          2'd1:    ram_wd = pc1_q;
          default: ram_wd = pc2_q;
        endcase
        pk_d = pk_q + 2'd1;
        if (pk_q == npc_q - 2'd1) begin
          count_d = count_q + CW'(npc_q - 2'd1);
          rp_d = '0; w_d = '0; pv_d = 1'b0; sum_d = '0;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        // compact pass: merge free runs after a free or a place, and sum free bytes
        if (rp_q < count_q) begin
          rv_d = 1'b1;
          rp_d = rp_q + 1'b1;
        end
        if (rv_q) begin
          if (pv_q && merge_q && !ram_rd.used && !pend_q.used) begin
            pend_d.len = (mlen[33:32] != 2'b00) ? '1 : mlen[31:0];
          end else begin
            if (pv_q) begin
              ram_we = 1'b1;
              wa_full = w_q;
              w_d = w_q + 1'b1;
              sum_d = sum_nx;
            end
            pend_d = ram_rd;
            pv_d = 1'b1;
          end
        end
        if (!rv_q && rp_q >= count_q) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        ram_we = 1'b1;
        wa_full = w_q;
        sum_d = sum_nx;
        count_d = w_q + 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d = st_q;
          gout_d = grant_q;
          free_d = sum_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // register writes rebuild the table
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_POOL_BASE) begin
        base_d = cfg_wdata_i;
      end else begin
        plen_d = cfg_wdata_i;
      end
      count_d = CW'(1);
      init_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q <= 1'b1;
      base_q <= POOL_RST;
      plen_q <= POOL_RST;
      count_q <= CW'(1);
      rp_q <= '0;
      rv_q <= 1'b0;
      hit_q <= 1'b0;
      ex_q <= 1'b0;
      found_q <= 1'b0;
      npc_q <= '0;
      pk_q <= '0;
      w_q <= '0;
      pv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q <= init_d;
      base_q <= base_d;
      plen_q <= plen_d;
      count_q <= count_d;
      rp_q <= rp_d;
      rv_q <= rv_d;
      hit_q <= hit_d;
      ex_q <= ex_d;
      found_q <= found_d;
      npc_q <= npc_d;
      pk_q <= pk_d;
      w_q <= w_d;
      pv_q <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    size_q <= size_d;
    addr_q <= addr_d;
    ri_q <= ri_d;
    hidx_q <= hidx_d;
    hseg_q <= hseg_d;
    eidx_q <= eidx_d;
    eseg_q <= eseg_d;
    sidx_q <= sidx_d;
    sseg_q <= sseg_d;
    diff_q <= diff_d;
    pc0_q <= pc0_d;
    pc1_q <= pc1_d;
    pc2_q <= pc2_d;
    st_q <= st_d;
    grant_q <= grant_d;
    merge_q <= merge_d;
    pend_q <= pend_d;
    sum_q <= sum_d;
    status_q <= status_d;
    gout_q <= gout_d;
    free_q <= free_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign grant_address_o = gout_q;
  assign free_bytes_o = free_q;

endmodule

// ===== hdl/ffsa_checker.sv =====
`include "first_fit_segment_allocator_assert.svh"

module ffsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] grant_address_o,
  input logic [31:0] free_bytes_o
);
  import ffsa_pkg::*;

  // a waiting result holds
  `FFSA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(grant_address_o) && $stable(free_bytes_o), "result changed while stalled")

  // failed requests never grant an address
  `FFSA_ASSERT_SAME(a_fail_no_grant, out_valid_o && status_o != STAT_OK, grant_address_o == '0, "grant on failure")

  // an accepted request keeps the block busy
  `FFSA_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready right after request")

  // a register write rebuilds the table before the next request
  `FFSA_ASSERT_NEXT(a_busy_after_cfg, cfg_we_i, !in_ready_o, "ready right after register write")

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);
